// ===== sv/etc1_pkg.sv =====
// Shared types, constants and helpers for the ETC1 block decoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package etc1_pkg;

	// Entries in the queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Intensity modifiers, indexed by table selector and texel index
	localparam logic signed [8:0] MOD_TBL [8][4] = '{
		'{ 9'sd2,  9'sd8,   -9'sd2,  -9'sd8   },
		'{ 9'sd5,  9'sd17,  -9'sd5,  -9'sd17  },
		'{ 9'sd9,  9'sd29,  -9'sd9,  -9'sd29  },
		'{ 9'sd13, 9'sd42,  -9'sd13, -9'sd42  },
		'{ 9'sd18, 9'sd60,  -9'sd18, -9'sd60  },
		'{ 9'sd24, 9'sd80,  -9'sd24, -9'sd80  },
		'{ 9'sd33, 9'sd106, -9'sd33, -9'sd106 },
		'{ 9'sd47, 9'sd183, -9'sd47, -9'sd183 }
	};

	// Decoded block handed from front to back; channel 0 is red, 2 is blue
	typedef struct packed {
		logic [2:0][7:0] base0;
		logic [2:0][7:0] base1;
		logic [2:0]      sel0;
		logic [2:0]      sel1;
		logic            flip;
		logic [31:0]     idx_planes;
		logic [63:0]     alpha_nib;
	} blk_t;

	function automatic logic [7:0] expand4(input logic [3:0] n);
		expand4 = {n, n};
	endfunction

	// 5-to-8 expansion of a value that may have wrapped past 5 bits
	function automatic logic [7:0] expand5w(input logic [7:0] n);
		expand5w = {n[4:0], 3'b000} | {2'b00, n[7:2]};
	endfunction

endpackage

// ===== sv/etc1_front.sv =====
// Front end: holds the alpha_present register, accepts blocks and decodes
// base colors, selectors and flip into a blk_t record. Depends on etc1_pkg.
module etc1_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_data,
	input  logic               start,
	input  logic               full,
	input  logic [63:0]        alpha_bits,
	input  logic [63:0]        color_bits,
	output logic               push,
	output etc1_pkg::blk_t     push_blk
);

	logic       alpha_present_q;
	logic [7:0] dsum [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_present_q <= 1'b0;
		end else if (cfg_we) begin
			alpha_present_q <= cfg_data;
		end
	end

	assign push = start & ~full;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			// base + signed delta, wrapped to 8 bits
			dsum[c] = {3'b000, color_bits[59-8*c +: 5]}
				+ {{5{color_bits[58-8*c]}}, color_bits[56-8*c +: 3]};
		end
	end

	always_comb begin
		push_blk = '0;
		for (int c = 0; c < 3; c++) begin
			if (color_bits[33]) begin
				push_blk.base0[c] = etc1_pkg::expand5w({3'b000, color_bits[59-8*c +: 5]});
				push_blk.base1[c] = etc1_pkg::expand5w(dsum[c]);
			end else begin
				push_blk.base0[c] = etc1_pkg::expand4(color_bits[60-8*c +: 4]);
				push_blk.base1[c] = etc1_pkg::expand4(color_bits[56-8*c +: 4]);
			end
		end
		push_blk.sel0       = color_bits[39:37];
		push_blk.sel1       = color_bits[36:34];
		push_blk.flip       = color_bits[32];
		push_blk.idx_planes = color_bits[31:0];
		// absent alpha: all-ones nibbles expand to 255
		push_blk.alpha_nib  = alpha_present_q ? alpha_bits : {64{1'b1}};
	end

endmodule

// ===== sv/etc1_queue.sv =====
// Short queue of decoded blocks between front and back end.
// Depends on etc1_pkg for blk_t and the depth constants.
module etc1_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  etc1_pkg::blk_t     push_blk,
	input  logic               pop,
	output logic               full,
	output logic               head_valid,
	output etc1_pkg::blk_t     head_blk
);

	etc1_pkg::blk_t                      ent_q [etc1_pkg::QDEPTH];
	logic [etc1_pkg::QPTR_W-1:0]         wr_ptr_q;
	logic [etc1_pkg::QPTR_W-1:0]         rd_ptr_q;
	logic [etc1_pkg::QCNT_W-1:0]         cnt_q;
	logic                                do_pop;

	assign full       = (cnt_q == etc1_pkg::QCNT_W'(etc1_pkg::QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_blk   = ent_q[rd_ptr_q];
	assign do_pop     = pop & head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_blk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == etc1_pkg::QPTR_W'(etc1_pkg::QDEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == etc1_pkg::QPTR_W'(etc1_pkg::QDEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== sv/etc1_back.sv =====
// Back end: walks the sixteen texels of a decoded block in column-major
// order and registers one RGBA beat per cycle. Depends on etc1_pkg.
module etc1_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  etc1_pkg::blk_t     head_blk,
	output logic               pop,
	output logic               texel_valid,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue,
	output logic [7:0]         alpha,
	output logic [1:0]         texel_x,
	output logic [1:0]         texel_y,
	output logic               last_texel
);

	etc1_pkg::blk_t   blk_q;
	logic             active_q;
	logic [3:0]       cnt_q;

	logic [1:0]       idx;
	logic             half;
	logic [2:0]       sel;
	logic signed [8:0] modv;
	logic [2:0][7:0]  base;
	logic [2:0][7:0]  chan;
	logic signed [9:0] sum [3];
	logic [3:0]       anib;

	logic             valid_s1;
	logic [2:0][7:0]  chan_s1;
	logic [7:0]       alpha_s1;
	logic [3:0]       pos_s1;

	assign pop = head_valid & (~active_q | (cnt_q == 4'd15));

	always_ff @(posedge clk) begin
		if (pop) begin
			blk_q <= head_blk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			active_q <= pop | (active_q & (cnt_q != 4'd15));
			if (pop) begin
				cnt_q <= '0;
			end else if (active_q) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// texel i: x = i[3:2], y = i[1:0]
	always_comb begin
		idx  = {blk_q.idx_planes[{1'b1, cnt_q}], blk_q.idx_planes[{1'b0, cnt_q}]};
		half = blk_q.flip ? cnt_q[1] : cnt_q[3];
		sel  = half ? blk_q.sel1 : blk_q.sel0;
		base = half ? blk_q.base1 : blk_q.base0;
		modv = etc1_pkg::MOD_TBL[sel][idx];
		anib = blk_q.alpha_nib[{cnt_q, 2'b00} +: 4];
		for (int c = 0; c < 3; c++) begin
			sum[c] = $signed({2'b00, base[c]}) + $signed({modv[8], modv});
			if (sum[c][9]) begin
				chan[c] = 8'd0;
			end else if (sum[c][8]) begin
				chan[c] = 8'd255;
			end else begin
				chan[c] = sum[c][7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= active_q;
		end
	end

	always_ff @(posedge clk) begin
		if (active_q) begin
			chan_s1  <= chan;
			alpha_s1 <= etc1_pkg::expand4(anib);
			pos_s1   <= cnt_q;
		end
	end

	assign texel_valid = valid_s1;
	assign red         = chan_s1[0];
	assign green       = chan_s1[1];
	assign blue        = chan_s1[2];
	assign alpha       = alpha_s1;
	assign texel_x     = pos_s1[3:2];
	assign texel_y     = pos_s1[1:0];
	assign last_texel  = valid_s1 & (pos_s1 == 4'd15);

`ifndef NO_ASSERTIONS
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		last_texel |-> (texel_x == 2'd3) && (texel_y == 2'd3))
		else $error("last texel not at corner");

	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		texel_valid && !last_texel |=> texel_valid)
		else $error("gap inside a block's texel burst");

	a_walk: assert property (@(posedge clk) disable iff (!arst_n)
		texel_valid && !last_texel |=> {texel_x, texel_y} == $past({texel_x, texel_y}) + 4'd1)
		else $error("texel walk skipped or repeated");

	a_pop_gap: assert property (@(posedge clk) disable iff (!arst_n)
		pop && active_q |-> cnt_q == 4'd15)
		else $error("block taken before current one finished");
`endif

endmodule

// ===== sv/etc1_block_decoder.sv =====
// ETC1 block decoder. A block is taken when start is high and busy is low;
// it then leaves as sixteen texel beats, one per cycle, column-major, each
// marked by texel_valid for a single cycle with no way to hold it off. The
// back end's texel walk sets the rate at which blocks are taken. A block
// that finds the decoder empty passes the queue entry, the back end's
// block register and the texel output registers before its first beat.
// A two-block queue lets the next block be taken while the current one is
// still being emitted. Write alpha_present only while idle.
// Depends on etc1_pkg, etc1_front, etc1_queue and etc1_back.
module etc1_block_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] alpha_bits,
	input  logic [63:0] color_bits,
	output logic        texel_valid,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic [1:0]  texel_x,
	output logic [1:0]  texel_y,
	output logic        last_texel
);

	logic            push;
	etc1_pkg::blk_t  push_blk;
	logic            full;
	logic            head_valid;
	etc1_pkg::blk_t  head_blk;
	logic            pop;

	assign busy = full;

	etc1_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.start      (start),
		.full       (full),
		.alpha_bits (alpha_bits),
		.color_bits (color_bits),
		.push       (push),
		.push_blk   (push_blk)
	);

	etc1_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_blk   (push_blk),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head_blk   (head_blk)
	);

	etc1_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_blk    (head_blk),
		.pop         (pop),
		.texel_valid (texel_valid),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.alpha       (alpha),
		.texel_x     (texel_x),
		.texel_y     (texel_y),
		.last_texel  (last_texel)
	);

endmodule

// ===== bench/tb_etc1_block_decoder.sv =====
// Testbench for etc1_block_decoder: feeds ETC1 blocks, predicts the sixteen
// texels of each block and checks every texel beat in arrival order.
// Depends only on the RTL of the block under test.
module tb_etc1_block_decoder;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int REPORT_MAX     = 10;

	// Intensity modifiers per table selector and 2-bit texel code
	localparam int INTENSITY [8][4] = '{
		'{2, 8, -2, -8}, '{5, 17, -5, -17}, '{9, 29, -9, -29}, '{13, 42, -13, -42},
		'{18, 60, -18, -60}, '{24, 80, -24, -80}, '{33, 106, -33, -106},
		'{47, 183, -47, -183}
	};

	localparam logic [31:0] INDEX_PATTERNS [8] = '{
		32'h0000_0000, 32'h0000_FFFF, 32'hFFFF_0000, 32'hFFFF_FFFF,
		32'h00FF_0F0F, 32'hF0F0_FF00, 32'h5A5A_33CC, 32'hA5A5_CC33
	};

	typedef struct {
		logic [63:0] alpha_word;
		logic [63:0] color_word;
	} block_t;

	typedef struct packed {
		logic [7:0] r, g, b, a;
		logic [1:0] x, y;
		logic       last;
	} texel_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_data = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [63:0] alpha_bits = '0;
	logic [63:0] color_bits = '0;
	logic        texel_valid;
	logic [7:0]  red, green, blue, alpha;
	logic [1:0]  texel_x, texel_y;
	logic        last_texel;

	block_t block_queue [$];
	texel_t due_texels [$];
	block_t next_block;
	logic   alpha_on = 1'b0;
	int     gap_pct = 0;
	int     error_count = 0;
	int     quiet_cycles = 0;

	etc1_block_decoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.start      (start),
		.busy       (busy),
		.alpha_bits (alpha_bits),
		.color_bits (color_bits),
		.texel_valid(texel_valid),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.alpha      (alpha),
		.texel_x    (texel_x),
		.texel_y    (texel_y),
		.last_texel (last_texel)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// 5-to-8 expansion; the argument may have wrapped past 5 bits
	function automatic logic [7:0] widen5(input logic [7:0] n);
		return {n[4:0], 3'b000} | (n >> 2);
	endfunction

	function automatic logic [7:0] saturate(input logic [7:0] base, input int mod);
		int v;
		v = $signed({24'd0, base}) + mod;
		if (v < 0)
			return 8'd0;
		if (v > 255)
			return 8'd255;
		return v[7:0];
	endfunction

	function automatic logic [63:0] etc_word(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic [2:0] sel_a, input logic [2:0] sel_b,
			input logic diff, input logic flip, input logic [31:0] planes);
		return {r, g, b, sel_a, sel_b, diff, flip, planes};
	endfunction

	// Expand one block into its sixteen texels, column-major
	task automatic decode_block(input logic [63:0] aw, input logic [63:0] cw);
		logic [31:0] hi, lo;
		logic [7:0]  base [2][3];
		logic [7:0]  b5, d3, sum;
		logic [2:0]  sel [2];
		int          half, code, m;
		texel_t      t;
		hi = cw[63:32];
		lo = cw[31:0];
		sel[0] = hi[7:5];
		sel[1] = hi[4:2];
		for (int c = 0; c < 3; c++) begin
			if (hi[1]) begin
				b5 = {3'b000, hi[27 - 8 * c +: 5]};
				d3 = {{5{hi[26 - 8 * c]}}, hi[24 - 8 * c +: 3]};
				sum = b5 + d3;
				base[0][c] = widen5(b5);
				base[1][c] = widen5(sum);
			end else begin
				base[0][c] = {2{hi[28 - 8 * c +: 4]}};
				base[1][c] = {2{hi[24 - 8 * c +: 4]}};
			end
		end
		for (int i = 0; i < 16; i++) begin
			code = {lo[16 + i], lo[i]};
			half = hi[0] ? ((i & 3) >> 1) : (i >> 3);
			m = INTENSITY[sel[half]][code];
			t.r = saturate(base[half][0], m);
			t.g = saturate(base[half][1], m);
			t.b = saturate(base[half][2], m);
			t.a = alpha_on ? {2{aw[4 * i +: 4]}} : 8'hFF;
			t.x = 2'(i >> 2);
			t.y = 2'(i & 3);
			t.last = (i == 15);
			due_texels.push_back(t);
		end
	endtask

	task automatic flag_error(input string what, input texel_t want, input texel_t got);
		error_count++;
		if (error_count <= REPORT_MAX)
			$display({"%0t %s: expected r=%h g=%h b=%h a=%h x=%0d y=%0d last=%b,",
				" got r=%h g=%h b=%h a=%h x=%0d y=%0d last=%b"},
				$time, what, want.r, want.g, want.b, want.a, want.x, want.y, want.last,
				got.r, got.g, got.b, got.a, got.x, got.y, got.last);
	endtask

	task automatic queue_block(input logic [63:0] aw, input logic [63:0] cw);
		block_queue.push_back('{aw, cw});
	endtask

	task automatic queue_random(input int count);
		for (int k = 0; k < count; k++)
			queue_block({$urandom, $urandom}, {$urandom, $urandom});
	endtask

	// Write the register; only called with nothing in flight
	task automatic set_alpha(input logic on);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= on;
		@(posedge clk);
		cfg_we <= 1'b0;
		alpha_on = on;
	endtask

	// Hold until every queued block is taken and every texel has come back
	task automatic wait_idle();
		do
			@(negedge clk);
		while (block_queue.size() != 0 || start || due_texels.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Driver: predict on the accepting edge, then offer the next block or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			alpha_bits <= '0;
			color_bits <= '0;
		end else begin
			if (start && !busy)
				decode_block(alpha_bits, color_bits);
			if (!start || !busy) begin
				if (block_queue.size() != 0 && $urandom_range(99) >= gap_pct) begin
					next_block = block_queue.pop_front();
					start <= 1'b1;
					alpha_bits <= next_block.alpha_word;
					color_bits <= next_block.color_word;
				end else begin
					// drop start and put noise on the idle inputs
					start <= 1'b0;
					alpha_bits <= {$urandom, $urandom};
					color_bits <= {$urandom, $urandom};
				end
			end
		end
	end

	// Monitor: check each texel beat against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		texel_t got, want;
		if (!arst_n) begin
			quiet_cycles = 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			if ((start && !busy) || texel_valid)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (texel_valid) begin
				got = {red, green, blue, alpha, texel_x, texel_y, last_texel};
				if (due_texels.size() == 0) begin
					flag_error("texel with no block pending", '0, got);
				end else begin
					want = due_texels.pop_front();
					if (got !== want)
						flag_error("texel mismatch", want, got);
				end
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed blocks, alpha absent
		gap_pct = 13;
		set_alpha(1'b0);
		queue_block(64'h0, 64'h0);
		queue_block({64{1'b1}}, {64{1'b1}});
		for (int s = 0; s < 8; s++)
			queue_block({$urandom, $urandom}, etc_word(8'($urandom), 8'($urandom),
				8'($urandom), 3'(s), 3'(7 - s), s[0], s[1], INDEX_PATTERNS[s]));
		// differential sums that wrap above 31 and below 0
		queue_block(64'h0, etc_word({5'd31, 3'd3}, {5'd30, 3'd2}, {5'd29, 3'd3},
			3'd0, 3'd1, 1'b1, 1'b0, 32'h0F0F_00FF));
		queue_block(64'h0, etc_word({5'd0, 3'b100}, {5'd1, 3'b101}, {5'd3, 3'b100},
			3'd2, 3'd3, 1'b1, 1'b1, 32'hFF00_F0F0));
		// channels pinned at the top and the bottom
		queue_block(64'h0, etc_word(8'hFF, 8'hFF, 8'hFF, 3'd7, 3'd7, 1'b0, 1'b0,
			32'h0000_FFFF));
		queue_block(64'h0, etc_word(8'h00, 8'h00, 8'h00, 3'd7, 3'd7, 1'b0, 1'b1,
			32'hFFFF_FFFF));
		queue_block(64'h0123_4567_89AB_CDEF, etc_word(8'h1E, 8'h2D, 8'h3C, 3'd4, 3'd5,
			1'b0, 1'b1, 32'h5A5A_33CC));
		wait_idle();

		// Alpha carried in the block
		set_alpha(1'b1);
		queue_block(64'h0123_4567_89AB_CDEF, {$urandom, $urandom});
		queue_block(64'hFEDC_BA98_7654_3210, {$urandom, $urandom});
		queue_block(64'h0, {$urandom, $urandom});
		queue_block({64{1'b1}}, {$urandom, $urandom});
		queue_random(50);
		wait_idle();

		// Sparse feed; pause halfway until all texels are back
		gap_pct = 82;
		set_alpha(1'b0);
		queue_random(25);
		wait_idle();
		queue_random(25);
		wait_idle();

		// Back-to-back feed
		gap_pct = 0;
		set_alpha(1'b1);
		queue_random(40);
		wait_idle();

		if (error_count == 0 && due_texels.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
